FILE: sv/set_assoc_lru_cache_lookup_unit_defines.svh
// ----------------------------------------------------------------------------
// Set-associative LRU cache lookup: assertion macros
// Shared macros for the concurrent assertions of the lookup unit.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_LRU_CACHE_LOOKUP_UNIT_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_LOOKUP_UNIT_DEFINES_SVH

// The property must hold at every clock edge outside reset.
`define SALC_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// The expression must never be true outside reset.
`define SALC_ASSERT_NEVER(lbl, clk, rst, expr, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error(msg);

`endif

FILE: sv/salc_pkg.sv
// ----------------------------------------------------------------------------
// Set-associative LRU cache lookup: package
// Field widths, default geometry and the controller to datapath signal groups.
// ----------------------------------------------------------------------------
package salc_pkg;

   localparam int ADDR_WIDTH      = 48;
   localparam int WAY_FIELD_WIDTH = 3;

   localparam int DEF_SETS        = 2048;
   localparam int DEF_WAYS        = 8;
   localparam int DEF_BLOCK_BYTES = 16;
   localparam int DEF_ADDR_BITS   = 48;

   typedef struct packed {
      logic clear_step;
      logic start_read;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
   } status_type;

endpackage

FILE: sv/salc_req_if.sv
// ----------------------------------------------------------------------------
// Set-associative LRU cache lookup: request channel
// Valid/ready channel carrying one byte address per word.
// ----------------------------------------------------------------------------
interface salc_req_if;
   import salc_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [ADDR_WIDTH-1:0] byte_address;

   modport source (output valid, output byte_address, input ready);
   modport sink (input valid, input byte_address, output ready);
   modport monitor (input valid, input byte_address, input ready);
endinterface

FILE: sv/salc_rsp_if.sv
// ----------------------------------------------------------------------------
// Set-associative LRU cache lookup: response channel
// Valid/ready channel carrying the lookup outcome per word.
// ----------------------------------------------------------------------------
interface salc_rsp_if;
   import salc_pkg::*;

   logic                       valid;
   logic                       ready;
   logic                       hit;
   logic [WAY_FIELD_WIDTH-1:0] way_used;
   logic                       evicted_valid;

   modport source (output valid, output hit, output way_used, output evicted_valid,
                   input ready);
   modport sink (input valid, input hit, input way_used, input evicted_valid,
                 output ready);
   modport monitor (input valid, input hit, input way_used, input evicted_valid,
                    input ready);
endinterface

FILE: sv/salc_ctrl.sv
// ----------------------------------------------------------------------------
// Set-associative LRU cache lookup: controller
// Sequences the post-reset clearing pass, the set read and the write-back.
// ----------------------------------------------------------------------------
module salc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output salc_pkg::cmd_type    cmd,
   input  salc_pkg::status_type status
);
   import salc_pkg::*;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign req_ready      = (state_ff == ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign cmd.clear_step = (state_ff == ST_CLEAR);
   assign cmd.start_read = (state_ff == ST_IDLE) && req_valid;
   assign cmd.commit     = (state_ff == ST_LOOKUP) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_CLEAR: begin
               if (status.clear_last) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_LOOKUP;
               end
            end
            ST_LOOKUP: begin
               if (cmd.commit) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_CLEAR;
            end
         endcase
      end
   end

endmodule

FILE: sv/salc_dpath.sv
// ----------------------------------------------------------------------------
// Set-associative LRU cache lookup: datapath
// Set memories, tag compare, victim choice, rank update and result register.
// ----------------------------------------------------------------------------
module salc_dpath #(
   parameter int SETS        = salc_pkg::DEF_SETS,
   parameter int WAYS        = salc_pkg::DEF_WAYS,
   parameter int BLOCK_BYTES = salc_pkg::DEF_BLOCK_BYTES,
   parameter int ADDR_BITS   = salc_pkg::DEF_ADDR_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  salc_pkg::cmd_type                    cmd,
   output salc_pkg::status_type                 status,
   input  logic [salc_pkg::ADDR_WIDTH-1:0]      req_byte_address,
   output logic                                 rsp_hit,
   output logic [salc_pkg::WAY_FIELD_WIDTH-1:0] rsp_way_used,
   output logic                                 rsp_evicted_valid
);
   import salc_pkg::*;

   localparam int OFF_BITS     = $clog2(BLOCK_BYTES);
   localparam int SET_BITS     = $clog2(SETS);
   localparam int SET_IDX_BITS = (SET_BITS > 0) ? SET_BITS : 1;
   localparam int TAG_RAW      = ADDR_BITS - OFF_BITS - SET_BITS;
   localparam int TAG_BITS     = (TAG_RAW > 0) ? TAG_RAW : 1;
   localparam int WAY_IDX_BITS = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int RANK_BITS    = WAY_IDX_BITS;
   localparam logic [63:0] ADDR_MASK =
      (ADDR_BITS >= 64) ? {64{1'b1}} : ((64'd1 << ADDR_BITS) - 64'd1);
   localparam logic [SET_IDX_BITS-1:0] SET_MASK = SET_IDX_BITS'(SETS - 1);
   localparam logic [SET_IDX_BITS-1:0] CLEAR_LAST = SET_IDX_BITS'(SETS - 1);

   typedef logic [WAYS-1:0]                valid_row_type;
   typedef logic [WAYS-1:0][RANK_BITS-1:0] rank_row_type;
   typedef logic [WAYS-1:0][TAG_BITS-1:0]  tag_row_type;

   valid_row_type valid_mem [SETS];
   rank_row_type  rank_mem [SETS];
   tag_row_type   tag_mem [SETS];

   logic [63:0]               addr_masked;
   logic [63:0]               block_num;
   logic [SET_IDX_BITS-1:0]   req_set;
   logic [TAG_BITS-1:0]       req_tag;

   logic [SET_IDX_BITS-1:0]   clear_idx_ff;
   logic [SET_IDX_BITS-1:0]   set_ff;
   logic [TAG_BITS-1:0]       tag_ff;
   valid_row_type             rd_valid_ff;
   rank_row_type              rd_rank_ff;
   tag_row_type               rd_tag_ff;

   logic [WAYS-1:0]           hit_vec;
   logic                      any_hit;
   logic [WAY_IDX_BITS-1:0]   hit_way;
   logic [WAY_IDX_BITS-1:0]   victim_way;
   logic [WAY_IDX_BITS-1:0]   lru_way;
   logic [RANK_BITS-1:0]      lru_rank;
   logic [WAY_IDX_BITS-1:0]   inv_way;
   logic                      found_inv;
   logic [WAY_IDX_BITS-1:0]   used_way;
   logic                      was_valid;
   logic [RANK_BITS-1:0]      old_rank;
   valid_row_type             valid_next;
   rank_row_type              rank_next;
   tag_row_type               tag_next;

   logic                      hit_ff;
   logic [WAY_FIELD_WIDTH-1:0] way_ff;
   logic                      evict_ff;

   assign addr_masked = 64'(req_byte_address) & ADDR_MASK;
   assign block_num   = addr_masked >> OFF_BITS;
   assign req_set     = SET_IDX_BITS'(block_num) & SET_MASK;
   assign req_tag     = TAG_BITS'(block_num >> SET_BITS);

   assign status.clear_last = (clear_idx_ff == CLEAR_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_idx_ff <= '0;
      end else if (cmd.clear_step) begin
         clear_idx_ff <= clear_idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_read) begin
         set_ff      <= req_set;
         tag_ff      <= req_tag;
         rd_valid_ff <= valid_mem[req_set];
         rd_rank_ff  <= rank_mem[req_set];
         rd_tag_ff   <= tag_mem[req_set];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         valid_mem[clear_idx_ff] <= '0;
         rank_mem[clear_idx_ff]  <= '0;
      end else if (cmd.commit) begin
         valid_mem[set_ff] <= valid_next;
         rank_mem[set_ff]  <= rank_next;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         tag_mem[set_ff] <= tag_next;
      end
   end

   always_comb begin
      hit_way = '0;
      for (int w = 0; w < WAYS; w++) begin
         hit_vec[w] = rd_valid_ff[w] && (rd_tag_ff[w] == tag_ff);
      end
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) begin
            hit_way = WAY_IDX_BITS'(w);
         end
      end
      any_hit = |hit_vec;
   end

   always_comb begin
      lru_way   = '0;
      lru_rank  = rd_rank_ff[0];
      inv_way   = '0;
      found_inv = 1'b0;
      for (int w = 1; w < WAYS; w++) begin
         if (rd_rank_ff[w] > lru_rank) begin
            lru_rank = rd_rank_ff[w];
            lru_way  = WAY_IDX_BITS'(w);
         end
      end
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (!rd_valid_ff[w]) begin
            inv_way   = WAY_IDX_BITS'(w);
            found_inv = 1'b1;
         end
      end
      victim_way = found_inv ? inv_way : lru_way;
   end

   assign used_way  = any_hit ? hit_way : victim_way;
   assign was_valid = rd_valid_ff[used_way];
   assign old_rank  = rd_rank_ff[used_way];

   always_comb begin
      valid_next = rd_valid_ff;
      rank_next  = rd_rank_ff;
      tag_next   = rd_tag_ff;
      for (int w = 0; w < WAYS; w++) begin
         if (WAY_IDX_BITS'(w) == used_way) begin
            valid_next[w] = 1'b1;
            rank_next[w]  = '0;
            tag_next[w]   = tag_ff;
         end else if (rd_valid_ff[w] && (!was_valid || (rd_rank_ff[w] < old_rank))) begin
            rank_next[w] = rd_rank_ff[w] + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         hit_ff   <= any_hit;
         way_ff   <= WAY_FIELD_WIDTH'(used_way);
         evict_ff <= !any_hit && was_valid;
      end
   end

   assign rsp_hit           = hit_ff;
   assign rsp_way_used      = way_ff;
   assign rsp_evicted_valid = evict_ff;

endmodule

FILE: sv/set_assoc_lru_cache_lookup_unit.sv
// One step reads the set rows from the set memories into registers, the
// next compares tags and writes the updated row back, waiting while an
// earlier response word is stalled; no new word is accepted until the write-back.
// Reset: synchronous; a clearing pass zeroes the valid and rank rows of all
// SETS sets (2048 by default) one set per cycle, with req ready held low.
// ----------------------------------------------------------------------------
// Set-associative LRU cache lookup unit
// Tag-only set-associative cache directory with least recently used
// replacement, reporting hit, way used and eviction for each address.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_lookup_unit #(
   parameter int SETS        = salc_pkg::DEF_SETS,
   parameter int WAYS        = salc_pkg::DEF_WAYS,
   parameter int BLOCK_BYTES = salc_pkg::DEF_BLOCK_BYTES,
   parameter int ADDR_BITS   = salc_pkg::DEF_ADDR_BITS
) (
   input logic        clock,
   input logic        reset,
   salc_req_if.sink   req_chan,
   salc_rsp_if.source rsp_chan
);
   import salc_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;
   logic       rsp_valid;

   salc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   salc_dpath #(
      .SETS        (SETS),
      .WAYS        (WAYS),
      .BLOCK_BYTES (BLOCK_BYTES),
      .ADDR_BITS   (ADDR_BITS)
   ) u_dpath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_byte_address  (req_chan.byte_address),
      .rsp_hit           (rsp_chan.hit),
      .rsp_way_used      (rsp_chan.way_used),
      .rsp_evicted_valid (rsp_chan.evicted_valid)
   );

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

endmodule

FILE: sv/salc_checker.sv
// ----------------------------------------------------------------------------
// Set-associative LRU cache lookup: port checker
// Concurrent assertions on the ports of the lookup unit, bound to the top.
// ----------------------------------------------------------------------------
`include "set_assoc_lru_cache_lookup_unit_defines.svh"

module salc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic                                 rsp_hit,
   input logic [salc_pkg::WAY_FIELD_WIDTH-1:0] rsp_way_used,
   input logic                                 rsp_evicted_valid
);

   `SALC_ASSERT(a_busy_after_accept, clock, reset, req_valid && req_ready |=> !req_ready, "request accepted while a lookup was in progress")

   `SALC_ASSERT(a_rsp_after_lookup, clock, reset, $rose(rsp_valid) |-> !$past(req_ready), "response raised without a lookup in progress")

   `SALC_ASSERT_NEVER(a_hit_no_evict, clock, reset, rsp_valid && rsp_hit && rsp_evicted_valid, "hit reported together with an eviction")

   `SALC_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit) && $stable(rsp_way_used) && $stable(rsp_evicted_valid), "stalled response word changed")

endmodule

bind set_assoc_lru_cache_lookup_unit salc_checker u_salc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_hit           (rsp_chan.hit),
   .rsp_way_used      (rsp_chan.way_used),
   .rsp_evicted_valid (rsp_chan.evicted_valid)
);

FILE: test/tb_set_assoc_lru_cache_lookup_unit.sv
// ----------------------------------------------------------------------------
// Set-associative LRU cache lookup unit: testbench
// Drives byte addresses into the lookup unit and holds its own copy of the
// cache directory: valid bits, tags and recency ranks. Each accepted address
// updates that copy and queues the expected hit, way and eviction outcome.
// Each response word is then compared with the oldest queued outcome. A short
// directed sequence fills, hits and evicts within one set and covers the
// address extremes. A long random sequence follows, mostly from a small pool
// of sets and tags so that hits and evictions are frequent, with random
// idling and back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb_set_assoc_lru_cache_lookup_unit;
   import salc_pkg::*;

   localparam int SETS       = DEF_SETS;
   localparam int WAYS       = DEF_WAYS;
   localparam int OFF_BITS   = $clog2(DEF_BLOCK_BYTES);
   localparam int SET_BITS   = $clog2(SETS);
   localparam int TAG_W      = ADDR_WIDTH - OFF_BITS - SET_BITS;
   localparam int LINES      = SETS * WAYS;
   localparam int RANDOM_N   = 1950;
   localparam int HOLD_OFF   = 300;
   localparam int IDLE_LIMIT = 10000;
   localparam int DRAIN      = 20;

   typedef logic [ADDR_WIDTH-1:0] addr_type;
   typedef logic [TAG_W-1:0]      tag_type;
   typedef logic [SET_BITS-1:0]   set_type;

   typedef struct packed {
      logic                       hit;
      logic [WAY_FIELD_WIDTH-1:0] way_used;
      logic                       evicted_valid;
   } lookup_result_type;

   class lru_directory_scoreboard;
      bit                line_valid [LINES];
      tag_type           line_tag [LINES];
      bit [2:0]          line_rank [LINES];
      lookup_result_type expected_lookups [$];
      int unsigned       mismatch_count;

      function new();
         for (int i = 0; i < LINES; i++) begin
            line_valid[i] = 1'b0;
            line_tag[i]   = '0;
            line_rank[i]  = '0;
         end
         mismatch_count = 0;
      endfunction

      function int pending();
         return expected_lookups.size();
      endfunction

      function void promote_way(int base, int used);
         bit       was_valid;
         bit [2:0] old_rank;
         was_valid = line_valid[base + used];
         old_rank  = line_rank[base + used];
         for (int w = 0; w < WAYS; w++) begin
            if (w != used && line_valid[base + w]) begin
               if (!was_valid || line_rank[base + w] < old_rank)
                  line_rank[base + w] = line_rank[base + w] + 3'd1;
            end
         end
         line_rank[base + used] = '0;
      endfunction

      function void note_access(addr_type addr);
         set_type           set_idx;
         tag_type           tag;
         int                base;
         int                used;
         int                best;
         bit                found;
         lookup_result_type outcome;
         set_idx = addr[OFF_BITS +: SET_BITS];
         tag     = addr[ADDR_WIDTH-1 -: TAG_W];
         base    = int'(set_idx) * WAYS;
         found   = 1'b0;
         used    = 0;
         for (int w = 0; w < WAYS; w++) begin
            if (!found && line_valid[base + w] && line_tag[base + w] == tag) begin
               found = 1'b1;
               used  = w;
            end
         end
         if (found) begin
            promote_way(base, used);
            outcome = '{hit: 1'b1, way_used: used[WAY_FIELD_WIDTH-1:0], evicted_valid: 1'b0};
         end else begin
            best = -1;
            for (int w = WAYS - 1; w >= 0; w--) begin
               if (!line_valid[base + w]) begin
                  used = w;
                  best = WAYS;
               end
            end
            if (best < 0) begin
               for (int w = 0; w < WAYS; w++) begin
                  if (int'(line_rank[base + w]) > best) begin
                     best = int'(line_rank[base + w]);
                     used = w;
                  end
               end
            end
            outcome = '{hit: 1'b0, way_used: used[WAY_FIELD_WIDTH-1:0],
                        evicted_valid: line_valid[base + used]};
            promote_way(base, used);
            line_tag[base + used]   = tag;
            line_valid[base + used] = 1'b1;
         end
         expected_lookups.push_back(outcome);
      endfunction

      task report_mismatch(string what);
         $display("[%0t] mismatch: %s", $realtime, what);
         mismatch_count++;
      endtask

      task check_response(lookup_result_type got);
         lookup_result_type want;
         if (expected_lookups.size() == 0) begin
            report_mismatch("response word with no lookup outstanding");
         end else begin
            want = expected_lookups.pop_front();
            if (got.hit !== want.hit)
               report_mismatch($sformatf("hit %b, expected %b", got.hit, want.hit));
            if (got.way_used !== want.way_used)
               report_mismatch($sformatf("way_used %0d, expected %0d",
                                         got.way_used, want.way_used));
            if (got.evicted_valid !== want.evicted_valid)
               report_mismatch($sformatf("evicted_valid %b, expected %b",
                                         got.evicted_valid, want.evicted_valid));
         end
      endtask
   endclass

   logic clock;
   logic reset;

   salc_req_if req_bus ();
   salc_rsp_if rsp_bus ();

   set_assoc_lru_cache_lookup_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   lru_directory_scoreboard directory_sb = new();

   bit      calm_phase   = 1'b0;
   bit      hold_off_rsp = 1'b0;
   tag_type tag_pool [16];
   set_type set_pool [4];

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic addr_type make_addr(tag_type tag, set_type set_idx,
                                          logic [OFF_BITS-1:0] off);
      return {tag, set_idx, off};
   endfunction

   function automatic addr_type random_addr();
      return addr_type'({$urandom, $urandom});
   endfunction

   task automatic send_word(addr_type addr);
      req_bus.valid        <= 1'b1;
      req_bus.byte_address <= addr;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic sender_idle(int cycles);
      req_bus.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Response side: random stalls, one long hold-off on request.
   initial begin
      rsp_bus.ready <= 1'b1;
      forever begin
         @(posedge clock);
         if (hold_off_rsp) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_OFF) @(posedge clock);
            hold_off_rsp = 1'b0;
            rsp_bus.ready <= 1'b1;
         end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_bus.valid && req_bus.ready)
            directory_sb.note_access(req_bus.byte_address);
         if (rsp_bus.valid && rsp_bus.ready)
            directory_sb.check_response('{hit: rsp_bus.hit, way_used: rsp_bus.way_used,
                                          evicted_valid: rsp_bus.evicted_valid});
      end
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      set_type  dir_set;
      int       pool_span;
      int       pick;
      addr_type addr;

      reset                <= 1'b1;
      req_bus.valid        <= 1'b0;
      req_bus.byte_address <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      tag_pool[0] = '0;
      tag_pool[1] = '1;
      for (int i = 2; i < 16; i++)
         tag_pool[i] = tag_type'({$urandom, $urandom});
      set_pool[0] = '0;
      set_pool[1] = '1;
      set_pool[2] = set_type'($urandom);
      set_pool[3] = set_type'($urandom);

      // Address extremes, then fill one set, hit it and evict from it.
      send_word('0);
      send_word('1);
      send_word(make_addr('0, '0, '1));
      dir_set = set_type'(5);
      for (int t = 1; t <= WAYS; t++)
         send_word(make_addr(tag_type'(t), dir_set, OFF_BITS'(t)));
      send_word(make_addr(tag_type'(1), dir_set, '0));
      send_word(make_addr(tag_type'(WAYS), dir_set, '0));
      send_word(make_addr(tag_type'(4), dir_set, '1));
      send_word(make_addr(tag_type'(100), dir_set, '0));
      send_word(make_addr(tag_type'(100), dir_set, '1));
      send_word(make_addr('1, dir_set, '0));
      send_word(make_addr(tag_type'(2), dir_set, '0));
      send_word(make_addr(tag_type'(3), dir_set, '0));
      send_word(make_addr('1, dir_set, '1));
      send_word(make_addr(tag_type'(7), dir_set, '0));
      send_word(make_addr('1, '1, '0));

      pool_span = 9;
      for (int n = 0; n < RANDOM_N; n++) begin
         if (n % 250 == 0) begin
            pick = $urandom_range(0, 3);
            pool_span = (pick == 0) ? 5 : (pick == 1) ? 9 : (pick == 2) ? 12 : 16;
         end
         if (n == 400)
            hold_off_rsp = 1'b1;
         if (n == 800) begin
            sender_idle(1);
            while (directory_sb.pending() != 0) @(posedge clock);
         end
         if (n == 1700)
            calm_phase = 1'b1;
         if ($urandom_range(0, 4) == 0)
            addr = random_addr();
         else
            addr = make_addr(tag_pool[$urandom_range(0, pool_span - 1)],
                             set_pool[$urandom_range(0, 3)],
                             OFF_BITS'($urandom));
         send_word(addr);
         if (!calm_phase && !(n >= 400 && n < 460) && $urandom_range(0, 4) == 0)
            sender_idle($urandom_range(1, 9));
      end
      sender_idle(1);

      while (directory_sb.pending() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (directory_sb.mismatch_count == 0 && directory_sb.pending() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
